FILE: rtl/bpc_pkg.sv
package bpc_pkg;

    localparam int RAW_W     = 24;
    localparam int COEF_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int DT_W      = 25;
    localparam int PRESS_W   = 32;
    localparam int TEMP_W    = 19;
    localparam int N_STAGES  = 8;

    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic signed [19:0] TEMP_REF_CENTI = 20'sd2000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS          = 3'd0,
        CFG_OFFSET        = 3'd1,
        CFG_SENS_TEMPCO   = 3'd2,
        CFG_OFFSET_TEMPCO = 3'd3,
        CFG_REF_TEMP      = 3'd4,
        CFG_TEMP_SENS     = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] offset;
        logic [COEF_W-1:0] sens_tempco;
        logic [COEF_W-1:0] offset_tempco;
        logic [COEF_W-1:0] ref_temp;
        logic [COEF_W-1:0] temp_sens;
    } coef_t;

    typedef struct packed {
        logic [RAW_W-1:0]        d1;
        logic signed [DT_W-1:0]  dt;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

FILE: rtl/bpc_cfg_regs.sv
module bpc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bpc_pkg::COEF_W-1:0]     cfg_data,
    output bpc_pkg::coef_t                 coef
);
    import bpc_pkg::*;

    coef_t coef_reg;
    coef_t coef_next;

    assign cfg_ready = 1'b1;
    assign coef      = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SENS:          coef_next.sens          = cfg_data;
                CFG_OFFSET:        coef_next.offset        = cfg_data;
                CFG_SENS_TEMPCO:   coef_next.sens_tempco   = cfg_data;
                CFG_OFFSET_TEMPCO: coef_next.offset_tempco = cfg_data;
                CFG_REF_TEMP:      coef_next.ref_temp      = cfg_data;
                CFG_TEMP_SENS:     coef_next.temp_sens     = cfg_data;
                default:           coef_next               = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

FILE: rtl/bpc_front.sv
module bpc_front (
    input  logic                        start,
    output logic                        busy,
    input  logic [bpc_pkg::RAW_W-1:0]   raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]   raw_temperature,
    input  logic [bpc_pkg::COEF_W-1:0]  coef_ref_temp,
    input  bpc_pkg::q_stat_t            stat,
    output logic                        push,
    output bpc_pkg::item_t              push_item
);
    import bpc_pkg::*;

    assign busy = stat.full;
    assign push = start && !busy;

    // The temperature difference is formed here so the queue carries it.
    always_comb
    begin
        push_item.d1 = raw_pressure;
        push_item.dt = $signed({1'b0, raw_temperature}) - $signed({1'b0, coef_ref_temp, 8'b0});
    end

endmodule

FILE: rtl/bpc_queue.sv
module bpc_queue #(
    parameter int DEPTH = bpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bpc_pkg::item_t    push_item,
    input  logic              pop,
    output bpc_pkg::item_t    head_item,
    output bpc_pkg::q_stat_t  stat
);
    import bpc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head_item  = entry_reg[rd_ptr_reg];
    assign stat.full  = (count_reg == FULL_CNT);
    assign stat.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

FILE: rtl/bpc_back.sv
module bpc_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bpc_pkg::coef_t                     coef,
    input  bpc_pkg::item_t                     head_item,
    input  bpc_pkg::q_stat_t                   stat,
    output logic                               pop,
    output logic                               result_valid,
    output logic signed [bpc_pkg::PRESS_W-1:0] pressure_pa,
    output logic signed [bpc_pkg::TEMP_W-1:0]  temp_centideg
);
    import bpc_pkg::*;

    logic [N_STAGES-1:0] valid_reg;
    logic [N_STAGES-1:0] valid_next;

    // Stage 1: products of dT.
    logic [RAW_W-1:0]   s1_d1_reg,    s1_d1_next;
    logic signed [41:0] s1_mtemp_reg, s1_mtemp_next;
    logic signed [41:0] s1_moff_reg,  s1_moff_next;
    logic signed [41:0] s1_msens_reg, s1_msens_next;
    logic signed [49:0] s1_mdt2_reg,  s1_mdt2_next;

    // Stage 2: first-order terms.
    logic [RAW_W-1:0]   s2_d1_reg,    s2_d1_next;
    logic signed [18:0] s2_dtemp_reg, s2_dtemp_next;
    logic signed [37:0] s2_off_reg,   s2_off_next;
    logic signed [37:0] s2_sens_reg,  s2_sens_next;
    logic [17:0]        s2_t2_reg,    s2_t2_next;
    logic               s2_low_reg,   s2_low_next;

    // Stage 3: square of the temperature deviation.
    logic [RAW_W-1:0]   s3_d1_reg,    s3_d1_next;
    logic [34:0]        s3_sq_reg,    s3_sq_next;
    logic signed [19:0] s3_temp_reg,  s3_temp_next;
    logic signed [37:0] s3_off_reg,   s3_off_next;
    logic signed [37:0] s3_sens_reg,  s3_sens_next;
    logic [17:0]        s3_t2_reg,    s3_t2_next;
    logic               s3_low_reg,   s3_low_next;
    logic signed [37:0] s3_sq_full;

    // Stage 4: second-order corrections.
    logic [RAW_W-1:0]   s4_d1_reg,    s4_d1_next;
    logic [35:0]        s4_off2_reg,  s4_off2_next;
    logic [34:0]        s4_sens2_reg, s4_sens2_next;
    logic signed [19:0] s4_temp_reg,  s4_temp_next;
    logic signed [37:0] s4_off_reg,   s4_off_next;
    logic signed [37:0] s4_sens_reg,  s4_sens_next;
    logic [36:0]        s4_five_sq;

    // Stage 5: corrected offset and sensitivity.
    logic [RAW_W-1:0]   s5_d1_reg,    s5_d1_next;
    logic signed [37:0] s5_off_reg,   s5_off_next;
    logic signed [37:0] s5_sens_reg,  s5_sens_next;
    logic signed [18:0] s5_temp_reg,  s5_temp_next;

    // Stage 6: partial products of D1 and SENS.
    logic [42:0]        s6_pplo_reg,  s6_pplo_next;
    logic signed [43:0] s6_pphi_reg,  s6_pphi_next;
    logic signed [37:0] s6_off_reg,   s6_off_next;
    logic signed [18:0] s6_temp_reg,  s6_temp_next;

    // Stage 7: full product, scaled.
    logic signed [41:0] s7_prod_reg,  s7_prod_next;
    logic signed [37:0] s7_off_reg,   s7_off_next;
    logic signed [18:0] s7_temp_reg,  s7_temp_next;
    logic signed [62:0] s7_sum;

    // Stage 8: result.
    logic signed [PRESS_W-1:0] s8_press_reg, s8_press_next;
    logic signed [TEMP_W-1:0]  s8_temp_reg,  s8_temp_next;
    logic signed [41:0]        s8_diff;

    assign pop           = !stat.empty;
    assign valid_next    = {valid_reg[N_STAGES-2:0], pop};
    assign result_valid  = valid_reg[N_STAGES-1];
    assign pressure_pa   = s8_press_reg;
    assign temp_centideg = s8_temp_reg;

    always_comb
    begin
        s1_d1_next    = head_item.d1;
        s1_mtemp_next = head_item.dt * $signed({1'b0, coef.temp_sens});
        s1_moff_next  = head_item.dt * $signed({1'b0, coef.offset_tempco});
        s1_msens_next = head_item.dt * $signed({1'b0, coef.sens_tempco});
        s1_mdt2_next  = head_item.dt * head_item.dt;
    end

    always_comb
    begin
        s2_d1_next    = s1_d1_reg;
        s2_dtemp_next = s1_mtemp_reg[41:23];
        s2_off_next   = $signed({6'b0, coef.offset, 16'b0})
                      + $signed({{3{s1_moff_reg[41]}}, s1_moff_reg[41:7]});
        s2_sens_next  = $signed({7'b0, coef.sens, 15'b0})
                      + $signed({{4{s1_msens_reg[41]}}, s1_msens_reg[41:8]});
        s2_t2_next    = s1_mdt2_reg[48:31];
        s2_low_next   = s1_mtemp_reg[41];
    end

    always_comb
    begin
        s3_sq_full   = s2_dtemp_reg * s2_dtemp_reg;
        s3_d1_next   = s2_d1_reg;
        s3_sq_next   = s3_sq_full[34:0];
        s3_temp_next = TEMP_REF_CENTI + $signed({s2_dtemp_reg[18], s2_dtemp_reg});
        s3_off_next  = s2_off_reg;
        s3_sens_next = s2_sens_reg;
        s3_t2_next   = s2_t2_reg;
        s3_low_next  = s2_low_reg;
    end

    always_comb
    begin
        s4_five_sq    = {s3_sq_reg, 2'b0} + {2'b0, s3_sq_reg};
        s4_d1_next    = s3_d1_reg;
        s4_off2_next  = s3_low_reg ? s4_five_sq[36:1] : '0;
        s4_sens2_next = s3_low_reg ? s4_five_sq[36:2] : '0;
        s4_temp_next  = s3_low_reg ? s3_temp_reg - $signed({2'b0, s3_t2_reg}) : s3_temp_reg;
        s4_off_next   = s3_off_reg;
        s4_sens_next  = s3_sens_reg;
    end

    always_comb
    begin
        s5_d1_next   = s4_d1_reg;
        s5_off_next  = s4_off_reg - $signed({2'b0, s4_off2_reg});
        s5_sens_next = s4_sens_reg - $signed({3'b0, s4_sens2_reg});
        s5_temp_next = s4_temp_reg[18:0];
    end

    always_comb
    begin
        s6_pplo_next = s5_d1_reg * s5_sens_reg[18:0];
        s6_pphi_next = $signed({1'b0, s5_d1_reg}) * $signed(s5_sens_reg[37:19]);
        s6_off_next  = s5_off_reg;
        s6_temp_next = s5_temp_reg;
    end

    always_comb
    begin
        s7_sum       = $signed({s6_pphi_reg, 19'b0}) + $signed({20'b0, s6_pplo_reg});
        s7_prod_next = s7_sum[62:21];
        s7_off_next  = s6_off_reg;
        s7_temp_next = s6_temp_reg;
    end

    always_comb
    begin
        s8_diff       = s7_prod_reg - $signed({{4{s7_off_reg[37]}}, s7_off_reg});
        s8_press_next = $signed({{5{s8_diff[41]}}, s8_diff[41:15]});
        s8_temp_next  = s7_temp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_d1_reg    <= s1_d1_next;
        s1_mtemp_reg <= s1_mtemp_next;
        s1_moff_reg  <= s1_moff_next;
        s1_msens_reg <= s1_msens_next;
        s1_mdt2_reg  <= s1_mdt2_next;

        s2_d1_reg    <= s2_d1_next;
        s2_dtemp_reg <= s2_dtemp_next;
        s2_off_reg   <= s2_off_next;
        s2_sens_reg  <= s2_sens_next;
        s2_t2_reg    <= s2_t2_next;
        s2_low_reg   <= s2_low_next;

        s3_d1_reg    <= s3_d1_next;
        s3_sq_reg    <= s3_sq_next;
        s3_temp_reg  <= s3_temp_next;
        s3_off_reg   <= s3_off_next;
        s3_sens_reg  <= s3_sens_next;
        s3_t2_reg    <= s3_t2_next;
        s3_low_reg   <= s3_low_next;

        s4_d1_reg    <= s4_d1_next;
        s4_off2_reg  <= s4_off2_next;
        s4_sens2_reg <= s4_sens2_next;
        s4_temp_reg  <= s4_temp_next;
        s4_off_reg   <= s4_off_next;
        s4_sens_reg  <= s4_sens_next;

        s5_d1_reg    <= s5_d1_next;
        s5_off_reg   <= s5_off_next;
        s5_sens_reg  <= s5_sens_next;
        s5_temp_reg  <= s5_temp_next;

        s6_pplo_reg  <= s6_pplo_next;
        s6_pphi_reg  <= s6_pphi_next;
        s6_off_reg   <= s6_off_next;
        s6_temp_reg  <= s6_temp_next;

        s7_prod_reg  <= s7_prod_next;
        s7_off_reg   <= s7_off_next;
        s7_temp_reg  <= s7_temp_next;

        s8_press_reg <= s8_press_next;
        s8_temp_reg  <= s8_temp_next;
    end

endmodule

FILE: rtl/baro_pressure_temp_compensation_top.sv
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// sample   | start, busy               | raw_pressure, raw_temperature
// config   | cfg_valid, cfg_ready      | cfg_index, cfg_data
// result   | result_valid (strobe)     | pressure_pa, temp_centideg
//
// One sample is taken per cycle while busy is low; each result passes through the
// queue register and then the eight-stage multiply pipeline on its way to the ports;
// the back end takes one item per clock from the queue.
// Reset clears the queue, the pipeline valid bits and the calibration words.
// The receiver cannot stall, so the back end drains the queue every cycle and
// busy rises only if the queue fills.
module baro_pressure_temp_compensation_top #(
    parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bpc_pkg::RAW_W-1:0]          raw_pressure,
    input  logic [bpc_pkg::RAW_W-1:0]          raw_temperature,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bpc_pkg::COEF_W-1:0]         cfg_data,
    output logic                               result_valid,
    output logic signed [bpc_pkg::PRESS_W-1:0] pressure_pa,
    output logic signed [bpc_pkg::TEMP_W-1:0]  temp_centideg
);
    import bpc_pkg::*;

    coef_t   coef;
    q_stat_t stat;
    item_t   push_item;
    item_t   head_item;
    logic    push;
    logic    pop;

    bpc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    bpc_front u_front (
        .start           (start),
        .busy            (busy),
        .raw_pressure    (raw_pressure),
        .raw_temperature (raw_temperature),
        .coef_ref_temp   (coef.ref_temp),
        .stat            (stat),
        .push            (push),
        .push_item       (push_item)
    );

    bpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .stat      (stat)
    );

    bpc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .coef          (coef),
        .head_item     (head_item),
        .stat          (stat),
        .pop           (pop),
        .result_valid  (result_valid),
        .pressure_pa   (pressure_pa),
        .temp_centideg (temp_centideg)
    );

endmodule
